>>> rtl/fdss_pkg.sv
package fdss_pkg;

    localparam int VALUE_W = 14;
    localparam int SEG_W   = 8;
    localparam int DIGITS  = 4;
    localparam int IDX_W   = $clog2(DIGITS);
    localparam int CODE_W  = 4;
    localparam int RADIX   = 10;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(DIGITS - 1);
    localparam logic [VALUE_W-1:0] WRAP_LIMIT = 14'd10000;
    localparam logic [SEG_W-1:0]   POINT_MASK = 8'h7F;
    localparam logic [SEG_W-1:0]   POINT_DARK = 8'hFF;
    localparam logic [DIGITS-1:0]  FIRST_SEL  = 4'b0001;

    // Active-low common-anode patterns for the digits 0 through 9.
    localparam logic [SEG_W-1:0] SEG_TABLE [RADIX] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
        8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    // Multiples 0..9 of each place value, thousands first.
    localparam logic [VALUE_W-1:0] PLACE_MULT [DIGITS][RADIX] = '{
        '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000,
          14'd5000, 14'd6000, 14'd7000, 14'd8000, 14'd9000},
        '{14'd0, 14'd100, 14'd200, 14'd300, 14'd400,
          14'd500, 14'd600, 14'd700, 14'd800, 14'd900},
        '{14'd0, 14'd10, 14'd20, 14'd30, 14'd40,
          14'd50, 14'd60, 14'd70, 14'd80, 14'd90},
        '{14'd0, 14'd1, 14'd2, 14'd3, 14'd4,
          14'd5, 14'd6, 14'd7, 14'd8, 14'd9}
    };

    typedef struct packed {
        logic [IDX_W-1:0]   point_digit;
        logic               point_on;
        logic [VALUE_W-1:0] value;
    } fdss_item_t;

endpackage

>>> rtl/four_digit_seven_segment_scan_core.sv
// Four-digit seven-segment scan core. Each input word carries a value, a
// decimal-point enable and the point position (0 is the leftmost digit);
// values above 9999 show as the value modulo 10000. For every input word the
// core sends four output words, thousands first, each holding the active-low
// common-anode segment byte (point in bit 7, cleared where lit) and the
// one-hot digit enable; tlast marks the rightmost digit. The digit scanner
// emits one output word per cycle while m_tready does not stall the output;
// the scanner takes the next input word in the cycle that it
// registers the last digit of the previous one, and a one-word input register
// lets the upstream side hand over a word while the scan is still in progress.
module four_digit_seven_segment_scan_core
    import fdss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // value [13:0], point_on [14], point_digit [16:15], zero fill above
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // segment_bits [7:0], digit_select [11:8], zero fill above
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    logic       item_valid;
    logic       item_ready;
    fdss_item_t item;

    fdss_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    fdss_digit_scan u_digit_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

>>> rtl/fdss_in_stage.sv
module fdss_in_stage
    import fdss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // value [13:0], point_on [14], point_digit [16:15], zero fill above
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                item_valid,
    input  logic                item_ready,
    output fdss_item_t          item
);

    logic         valid_reg;
    fdss_item_t   item_reg;
    fdss_item_t   item_next;
    logic [VALUE_W-1:0] raw_value;

    assign s_tready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // The field is at most 16383, so one subtraction brings it below 10000.
    always_comb
    begin
        raw_value             = s_tdata[VALUE_W-1:0];
        item_next.value       = (raw_value >= WRAP_LIMIT) ? raw_value - WRAP_LIMIT : raw_value;
        item_next.point_on    = s_tdata[VALUE_W];
        item_next.point_digit = s_tdata[VALUE_W+IDX_W:VALUE_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> rtl/fdss_digit_scan.sv
module fdss_digit_scan
    import fdss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  fdss_item_t          item,
    output logic                m_tvalid,
    input  logic                m_tready,
    // segment_bits [7:0], digit_select [11:8], zero fill above
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    logic               busy_reg;
    logic [VALUE_W-1:0] rem_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               point_on_reg;
    logic [IDX_W-1:0]   point_digit_reg;

    logic               out_valid_reg;
    logic [SEG_W-1:0]   seg_reg;
    logic [DIGITS-1:0]  sel_reg;
    logic               last_reg;

    logic               out_load;
    logic               step;
    logic               load;
    logic [CODE_W-1:0]  digit;
    logic [SEG_W-1:0]   seg_next;
    logic [VALUE_W-1:0] rem_next;

    assign out_load   = !out_valid_reg || m_tready;
    assign step       = busy_reg && out_load;
    assign item_ready = !busy_reg || (step && idx_reg == LAST_IDX);
    assign load       = item_valid && item_ready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - SEG_W - DIGITS){1'b0}}, sel_reg, seg_reg};
    assign m_tlast  = last_reg;

    // The multiples rise with the digit, so the highest one not above the
    // remainder gives the digit of the current place.
    always_comb
    begin
        digit = '0;
        for (int k = 1; k < RADIX; k++)
        begin
            if (rem_reg >= PLACE_MULT[idx_reg][k])
            begin
                digit = CODE_W'(k);
            end
        end
        rem_next = rem_reg - PLACE_MULT[idx_reg][digit];
        seg_next = SEG_TABLE[digit]
                 & ((point_on_reg && point_digit_reg == idx_reg) ? POINT_MASK : POINT_DARK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            // A new word arrives either while the scanner is idle or together with the
            // last digit step, and then it restarts the scan.
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            seg_reg  <= seg_next;
            sel_reg  <= FIRST_SEL << idx_reg;
            last_reg <= (idx_reg == LAST_IDX);
        end
        if (load)
        begin
            rem_reg         <= item.value;
            point_on_reg    <= item.point_on;
            point_digit_reg <= item.point_digit;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
        end
    end

    a_remainder_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < PLACE_MULT[idx_reg][RADIX-1] + PLACE_MULT[idx_reg][1]))
        else $error("remainder exceeds the range of the current place");

    a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && idx_reg == '0))
        else $error("a new word did not restart the scan at the leftmost digit");

    a_last_matches_select: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (last_reg == sel_reg[DIGITS-1] && $onehot(sel_reg)))
        else $error("digit enable and last flag disagree");

    a_no_accept_midscan: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && idx_reg != LAST_IDX) |-> !item_ready)
        else $error("new word taken before the scan finished");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import fdss_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 210;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 20;
    localparam int DIR_COUNT    = 15;

    // Active-low common-anode patterns, digit 0 first.
    localparam logic [7:0] SEG_PATTERN [10] = '{
        ~8'h3F, ~8'h06, ~8'h5B, ~8'h4F, ~8'h66,
        ~8'h6D, ~8'h7D, ~8'h07, ~8'h7F, ~8'h6F
    };
    localparam logic [7:0] POINT_LIT_MASK = 8'h7F;
    localparam int         SHOWN_MOD      = 10000;

    typedef struct packed {
        logic [7:0] seg;
        logic [3:0] sel;
        logic       last;
    } digit_word_t;

    // One row of the directed table. Where typed is set, typed_segs holds the
    // four segment bytes, leftmost digit in the top byte.
    typedef struct packed {
        logic [13:0] value;
        logic        point_on;
        logic [1:0]  point_digit;
        logic        typed;
        logic [31:0] typed_segs;
    } value_row_t;

    localparam value_row_t DIR_ROWS [DIR_COUNT] = '{
        '{14'd0,     1'b0, 2'd0, 1'b1, 32'hC0C0C0C0},
        '{14'd8888,  1'b1, 2'd0, 1'b1, 32'h00808080},
        '{14'd9999,  1'b1, 2'd3, 1'b1, 32'h90909010},
        '{14'd1234,  1'b0, 2'd2, 1'b1, 32'hF9A4B099},
        '{14'd10000, 1'b1, 2'd1, 1'b1, 32'hC040C0C0},
        '{14'd16383, 1'b1, 2'd2, 1'b0, 32'h0},
        '{14'd5678,  1'b1, 2'd1, 1'b0, 32'h0},
        '{14'd9090,  1'b1, 2'd2, 1'b0, 32'h0},
        '{14'd12345, 1'b0, 2'd3, 1'b0, 32'h0},
        '{14'd1000,  1'b1, 2'd3, 1'b0, 32'h0},
        '{14'd7,     1'b1, 2'd0, 1'b0, 32'h0},
        '{14'd4321,  1'b0, 2'd1, 1'b0, 32'h0},
        '{14'd6060,  1'b1, 2'd1, 1'b0, 32'h0},
        '{14'd10001, 1'b0, 2'd0, 1'b0, 32'h0},
        '{14'd16000, 1'b1, 2'd2, 1'b0, 32'h0}
    };

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // value [13:0], point_on [14], point_digit [16:15], zero fill above
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    // segment_bits [7:0], digit_select [11:8], zero fill above
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    digit_word_t pending_digits [$];
    int          mismatches;
    int          burst_left;

    four_digit_seven_segment_scan_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // Expected digit words for one accepted value, leftmost digit first.
    function automatic void queue_digits(fdss_item_t item, logic typed, logic [31:0] typed_segs);
        int          shown;
        int          place;
        digit_word_t word;
        shown = int'(item.value) % SHOWN_MOD;
        place = 1000;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (typed)
            begin
                word.seg = typed_segs[8 * (DIGITS - 1 - i) +: 8];
            end
            else
            begin
                word.seg = SEG_PATTERN[(shown / place) % 10];
                if (item.point_on && int'(item.point_digit) == i)
                begin
                    word.seg = word.seg & POINT_LIT_MASK;
                end
            end
            word.sel  = 4'(1 << i);
            word.last = (i == DIGITS - 1);
            pending_digits.push_back(word);
            place = place / 10;
        end
    endfunction

    // Sender bursts: a random gap of idle cycles, possibly none, opens each new burst.
    task automatic send_value(fdss_item_t item, logic typed, logic [31:0] typed_segs);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(item);
        do @(posedge clk); while (!s_tready);
        queue_digits(item, typed, typed_segs);
    endtask

    initial
    begin
        fdss_item_t item;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        mismatches = 0;
        burst_left = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_COUNT; r++)
        begin
            item.value       = DIR_ROWS[r].value;
            item.point_on    = DIR_ROWS[r].point_on;
            item.point_digit = DIR_ROWS[r].point_digit;
            send_value(item, DIR_ROWS[r].typed, DIR_ROWS[r].typed_segs);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(0, 7))
                0, 1:    item.value = 14'($urandom_range(0, 16383));
                2:       item.value = 14'($urandom_range(0, 20));
                3:       item.value = 14'(9999 - $urandom_range(0, 20));
                default: item.value = 14'($urandom_range(0, 9999));
            endcase
            item.point_on    = 1'($urandom_range(0, 1));
            item.point_digit = 2'($urandom_range(0, 3));
            send_value(item, 1'b0, 32'h0);
        end
        s_tvalid <= 1'b0;

        while (pending_digits.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Receiver stalls: each stall pattern is chosen at random and held for a random span before the next is drawn.
    initial
    begin
        int mode;
        int mode_left;
        int tick;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 64);
            end
            mode_left = mode_left - 1;
            tick      = tick + 1;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (tick % 8 == 7);
            endcase
        end
    end

    always @(posedge clk)
    begin
        digit_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_digits.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: unexpected digit word, got seg %h sel %b last %b",
                             $time, m_tdata[7:0], m_tdata[11:8], m_tlast);
                end
            end
            else
            begin
                want = pending_digits.pop_front();
                if (m_tdata[7:0] !== want.seg || m_tdata[11:8] !== want.sel
                    || m_tlast !== want.last)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("%0t: expected seg %h sel %b last %b, got seg %h sel %b last %b",
                                 $time, want.seg, want.sel, want.last,
                                 m_tdata[7:0], m_tdata[11:8], m_tlast);
                    end
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
